// File: rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console writer.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

    // Character codes with a control meaning, and the space
    localparam logic [7:0] CHR_BACKSPACE = 8'd8;
    localparam logic [7:0] CHR_TAB       = 8'd9;
    localparam logic [7:0] CHR_LINE_FEED = 8'd10;
    localparam logic [7:0] CHR_RETURN    = 8'd13;
    localparam logic [7:0] CHR_SPACE     = 8'h20;

    // Attribute and cell value after reset
    localparam logic [7:0]  ATTR_RESET  = 8'h07;
    localparam logic [15:0] CELL_RESET  = 16'h0720;

    // Field widths of the result transaction and of the input cell index
    localparam int ROW_OUT_W = 5;
    localparam int COL_OUT_W = 7;
    localparam int OFS_OUT_W = 11;
    localparam int IDX_W     = 11;

    // Operation classes decided by the front
    typedef enum logic [2:0] {
        OP_READ,
        OP_PLAIN,
        OP_TAB,
        OP_RETURN,
        OP_LINE_FEED,
        OP_BACKSPACE
    } op_t;

    // One queued command
    typedef struct packed {
        op_t              op;
        logic [7:0]       char_code;
        logic [IDX_W-1:0] cell_index;
    } cmd_t;

    // Back-end states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_TAB,
        ST_SCROLL,
        ST_READ_WAIT,
        ST_DONE
    } state_t;

    // Status from the back end
    typedef struct packed {
        logic       clearing;
        logic [7:0] row;
        logic [7:0] col;
    } status_t;

endpackage

`default_nettype wire

// File: rtl/tcw_front.sv
// ----------------------------------------------------------------------------
// tcw_front
// Accepts input transactions and classifies them into command entries.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_front
    import tcw_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // char_code[7:0], cell_index[18:8]
    input  wire logic        s_tuser,   // func
    input  wire logic        hold,
    input  wire logic        q_full,
    output logic             push,
    output cmd_t             cmd
);

    logic [7:0] chr;
    op_t        op;

    assign chr = s_tdata[7:0];

    // Stall while the queue is full or the screen is being cleared
    assign s_tready = !q_full && !hold && aresetn;
    assign push     = s_tvalid && s_tready;

    // Classify the character code
    always_comb begin
        if (s_tuser) begin
            op = OP_READ;
        end else begin
            unique case (chr)
                CHR_BACKSPACE: op = OP_BACKSPACE;
                CHR_TAB:       op = OP_TAB;
                CHR_LINE_FEED: op = OP_LINE_FEED;
                CHR_RETURN:    op = OP_RETURN;
                default:       op = OP_PLAIN;
            endcase
        end
    end

    assign cmd.op         = op;
    assign cmd.char_code  = chr;
    assign cmd.cell_index = s_tdata[18:8];

    // The front holds no state of its own; reset gates readiness, the clock is unused
    logic unused_clk;
    assign unused_clk = aclk;

endmodule

`default_nettype wire

// File: rtl/tcw_queue.sv
// ----------------------------------------------------------------------------
// tcw_queue
// Two-entry command queue between the front and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_queue
    import tcw_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  cmd_t      push_cmd,
    output logic      full,
    input  wire logic pop,
    output logic      not_empty,
    output cmd_t      head
);

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = slot_reg[rd_ptr_reg];

    // Advance pointers and count
    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed entry
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// File: rtl/tcw_back.sv
// ----------------------------------------------------------------------------
// tcw_back
// Executes commands on the screen memory and cursor, drives the result stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_back
    import tcw_pkg::*;
#(
    parameter int COLUMNS  = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STOP = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [7:0]  cfg_wr_data,
    input  wire logic        q_not_empty,
    input  cmd_t             q_head,
    output logic             q_pop,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,
    output status_t          status
);

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int MOVE   = (ROWS - 1) * COLUMNS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int CNT_W  = $clog2(CELLS + 1);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int PH_W   = $clog2(TAB_STOP);

    // Screen memory
    logic [15:0]       mem [CELLS];
    logic [15:0]       rd_q;
    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [15:0]       mem_wdata;

    // Control and cursor registers
    state_t            state_reg, state_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ADDR_W-1:0] base_reg, base_next;
    logic [PH_W-1:0]   phase_reg, phase_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [7:0]        attr_reg;
    logic [15:0]       val_reg, val_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [39:0]       m_tdata_reg, m_tdata_next;

    // Helpers
    logic [ADDR_W-1:0]       pos;
    logic [COL_W:0]          col_inc;
    logic                    last_row;
    logic                    do_plain;
    logic [7:0]              plain_chr;
    logic [15:0]             blank;
    logic [CNT_W-1:0]        cnt_src;
    logic [CNT_W-1:0]        cnt_dst;
    logic                    idx_ok;
    logic [ADDR_W+IDX_W-1:0] idx_ext;
    logic [ADDR_W+OFS_OUT_W-1:0] ofs_ext;
    logic [ROW_W+ROW_OUT_W-1:0]  row_ext;
    logic [COL_W+COL_OUT_W-1:0]  col_ext;

    assign pos      = base_reg + ADDR_W'(col_reg);
    assign col_inc  = {1'b0, col_reg} + (COL_W+1)'(1);
    assign last_row = (row_reg == ROW_W'(ROWS - 1));
    assign blank    = {attr_reg, CHR_SPACE};
    assign cnt_src  = cnt_reg + CNT_W'(COLUMNS);
    assign cnt_dst  = cnt_reg - CNT_W'(1);
    assign idx_ok   = ({21'd0, q_head.cell_index} < 32'(CELLS));
    assign idx_ext  = {{ADDR_W{1'b0}}, q_head.cell_index};
    assign ofs_ext  = {{OFS_OUT_W{1'b0}}, pos};
    assign row_ext  = {{ROW_OUT_W{1'b0}}, row_reg};
    assign col_ext  = {{COL_OUT_W{1'b0}}, col_reg};

    // Sequence the commands
    always_comb begin
        state_next    = state_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        base_next     = base_reg;
        phase_next    = phase_reg;
        cnt_next      = cnt_reg;
        val_next      = val_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        mem_we        = 1'b0;
        mem_waddr     = pos;
        mem_wdata     = blank;
        mem_re        = 1'b0;
        mem_raddr     = idx_ext[ADDR_W-1:0];
        q_pop         = 1'b0;
        do_plain      = 1'b0;
        plain_chr     = CHR_SPACE;

        unique case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg[ADDR_W-1:0];
                mem_wdata = CELL_RESET;
                cnt_next  = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(CELLS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (q_not_empty) begin
                    q_pop      = 1'b1;
                    val_next   = 16'd0;
                    state_next = ST_DONE;
                    unique case (q_head.op)
                        OP_READ: begin
                            if (idx_ok) begin
                                mem_re     = 1'b1;
                                state_next = ST_READ_WAIT;
                            end
                        end
                        OP_PLAIN: begin
                            do_plain  = 1'b1;
                            plain_chr = q_head.char_code;
                        end
                        OP_TAB: begin
                            if (phase_reg != '0) begin
                                state_next = ST_TAB;
                            end
                        end
                        OP_RETURN: begin
                            col_next   = '0;
                            phase_next = '0;
                        end
                        OP_LINE_FEED: begin
                            if (last_row) begin
                                cnt_next   = '0;
                                state_next = ST_SCROLL;
                            end else begin
                                row_next  = row_reg + ROW_W'(1);
                                base_next = base_reg + ADDR_W'(COLUMNS);
                            end
                        end
                        OP_BACKSPACE: begin
                            if (col_reg != '0) begin
                                col_next   = col_reg - COL_W'(1);
                                phase_next = (phase_reg == '0) ? PH_W'(TAB_STOP - 1)
                                                               : phase_reg - PH_W'(1);
                                mem_we     = 1'b1;
                                mem_waddr  = pos - ADDR_W'(1);
                            end
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_TAB: begin
                if (phase_reg == '0) begin
                    state_next = ST_DONE;
                end else begin
                    do_plain = 1'b1;
                end
            end
            ST_SCROLL: begin
                // Read one row ahead, write back the cell read last cycle
                if (cnt_reg < CNT_W'(MOVE)) begin
                    mem_re    = 1'b1;
                    mem_raddr = cnt_src[ADDR_W-1:0];
                end
                if (cnt_reg != '0) begin
                    mem_we    = 1'b1;
                    mem_waddr = cnt_dst[ADDR_W-1:0];
                    mem_wdata = (cnt_reg <= CNT_W'(MOVE)) ? rd_q : blank;
                end
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(CELLS)) begin
                    state_next = ST_DONE;
                end
            end
            ST_READ_WAIT: begin
                val_next   = rd_q;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {1'b0, val_reg, ofs_ext[OFS_OUT_W-1:0],
                                     col_ext[COL_OUT_W-1:0], row_ext[ROW_OUT_W-1:0]};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Write one character and advance the cursor
        if (do_plain) begin
            mem_we    = 1'b1;
            mem_waddr = pos;
            mem_wdata = {attr_reg, plain_chr};
            if (col_inc == (COL_W+1)'(COLUMNS)) begin
                col_next   = '0;
                phase_next = '0;
                if (last_row) begin
                    cnt_next   = '0;
                    state_next = ST_SCROLL;
                end else begin
                    row_next  = row_reg + ROW_W'(1);
                    base_next = base_reg + ADDR_W'(COLUMNS);
                end
            end else begin
                col_next   = col_inc[COL_W-1:0];
                phase_next = (phase_reg == PH_W'(TAB_STOP - 1)) ? '0
                                                                : phase_reg + PH_W'(1);
            end
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            row_reg      <= ROW_W'(ROWS - 1);
            col_reg      <= '0;
            base_reg     <= ADDR_W'(MOVE);
            phase_reg    <= '0;
            cnt_reg      <= '0;
            attr_reg     <= ATTR_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            base_reg     <= base_next;
            phase_reg    <= phase_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en) begin
                attr_reg <= cfg_wr_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        val_reg     <= val_next;
        m_tdata_reg <= m_tdata_next;
    end

    // Memory ports
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_q <= mem[mem_raddr];
        end
    end

    assign m_tvalid        = m_tvalid_reg;
    assign m_tdata         = m_tdata_reg;
    assign status.clearing = (state_reg == ST_CLEAR);
    assign status.row      = 8'(row_reg);
    assign status.col      = 8'(col_reg);

endmodule

`default_nettype wire

// File: rtl/text_console_writer_top.sv
// ----------------------------------------------------------------------------
// text_console_writer_top
// Text-mode console: character writes, cursor control, scrolling, cell reads.
//
// Channel   Dir  Handshake          Payload
// s_        in   s_tvalid/s_tready  s_tuser func, s_tdata char_code, cell_index
// m_        out  m_tvalid/m_tready  m_tdata row, col, offset, cell value
// cfg_      in   cfg_wr_en          cfg_wr_data text attribute
//
// Plain characters (unless they wrap off the last row), return and backspace
// go from idle to the result state in the back end; valid reads pass through
// a read-wait state first. A tab pads blanks up to the next tab stop, none
// when the cursor already sits on one. A scroll runs through the single-port-pair
// screen memory one cell a cycle. After reset, clearing holds s_tready low.
// A two-entry queue lets the input side run ahead while a result stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer_top
    import tcw_pkg::*;
#(
    parameter int COLUMNS  = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STOP = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // char_code[7:0], cell_index[18:8]
    input  wire logic        s_tuser,   // func
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // cursor_row[4:0], cursor_col[11:5],
                                        // cursor_offset[22:12], cell_value[38:23]
    input  wire logic        cfg_wr_en,
    input  wire logic [7:0]  cfg_wr_data
);

    logic    push, q_full, q_pop, q_not_empty;
    cmd_t    push_cmd, q_head;
    status_t status;

    tcw_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .hold     (status.clearing),
        .q_full   (q_full),
        .push     (push),
        .cmd      (push_cmd)
    );

    tcw_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    tcw_back #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .TAB_STOP (TAB_STOP)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .status      (status)
    );

    // No transaction enters during the clearing pass
    a_clear_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        status.clearing |-> !s_tready)
        else $error("input accepted during clearing pass");

    // Cursor stays on the screen
    a_row_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(status.row) < ROWS)
        else $error("cursor row out of range");

    a_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(status.col) < COLUMNS)
        else $error("cursor column out of range");

    // Nothing is popped while the screen is cleared
    a_no_pop_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        status.clearing |-> !q_pop)
        else $error("command popped during clearing pass");

endmodule

`default_nettype wire
